/* src/efra_pkg.sv */
`timescale 1ns / 1ps

package efra_pkg;

    localparam int START_W   = 40;
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int ROOM_W    = 4;
    localparam int CFG_W     = 5;
    localparam int ROOMS_DEF = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic [START_W-1:0] req_start;
        logic [START_W-1:0] end_time;
    } job_beat_t;

    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic [TIME_W-1:0] actual_start;
        logic [TIME_W-1:0] actual_end;
        logic [ROOM_W-1:0] busiest_room;
    } grant_beat_t;

    // scan record walking down the cell chain (room index travels beside it)
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [TIME_W-1:0]  best_time;
        logic [COUNT_W-1:0] best_count;
    } scan_rec_t;

    // write-back of the chosen room
    typedef struct packed {
        logic              en;
        logic [TIME_W-1:0] finish;
    } commit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

/* src/efra_cell.sv */
`timescale 1ns / 1ps

module efra_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [efra_pkg::CFG_W-1:0]           rooms_in_use,
    input  logic [efra_pkg::START_W-1:0]         req_start,
    input  efra_pkg::scan_rec_t                  rec_in,
    input  logic [IDX_W-1:0]                     pick_in,
    output efra_pkg::scan_rec_t                  rec_out,
    output logic [IDX_W-1:0]                     pick_out,
    input  efra_pkg::commit_t                    commit,
    input  logic [IDX_W-1:0]                     commit_pick
);

    localparam int TW = efra_pkg::TIME_W;
    localparam int SW = efra_pkg::START_W;
    localparam int CW = efra_pkg::COUNT_W;
    localparam int FW = efra_pkg::CFG_W;
    localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

    logic [TW-1:0]       free_reg;
    logic [CW-1:0]       count_reg;
    efra_pkg::scan_rec_t rec_reg;
    efra_pkg::scan_rec_t rec_next;
    logic [IDX_W-1:0]    pick_reg;
    logic [IDX_W-1:0]    pick_next;
    logic                active;
    logic                is_free;

    // room zero always takes part, even with a zero room count
    assign active  = (INDEX == 0) || ({{(32-FW){1'b0}}, rooms_in_use} > 32'(INDEX));
    assign is_free = free_reg <= {{(TW-SW){1'b0}}, req_start};

    always_comb
    begin
        rec_next  = rec_in;
        pick_next = pick_in;
        if (rec_in.valid && active && !rec_in.found)
        begin
            if (is_free)
            begin
                rec_next.found      = 1'b1;
                rec_next.best_time  = free_reg;
                rec_next.best_count = count_reg;
                pick_next           = ME;
            end
            // room zero seeds the earliest-free search, even when pinned at full scale
            else if ((INDEX == 0) || (free_reg < rec_in.best_time))
            begin
                rec_next.best_time  = free_reg;
                rec_next.best_count = count_reg;
                pick_next           = ME;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg  <= '0;
            pick_reg <= '0;
        end
        else
        begin
            rec_reg  <= rec_next;
            pick_reg <= pick_next;
        end
    end

    // booking state of this room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= '0;
            count_reg <= '0;
        end
        else if (commit.en && (commit_pick == ME))
        begin
            free_reg <= commit.finish;
            if (count_reg != {CW{1'b1}})
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    assign rec_out  = rec_reg;
    assign pick_out = pick_reg;

endmodule

/* src/earliest_free_room_allocator_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// job       in   job_valid / job_ready     job   (req_start, end_time)
// grant     out  grant_valid / grant_ready grant (room, actual_start, actual_end, busiest_room)
// config    in   wr_en                     wr_data (rooms_in_use)
//
// One job at a time: the next job beat waits for the scan record walking the
// cell chain one room per cycle and for the write-back of the grant.
// rst_n (async, active low) clears every room's free time and count, the
// busiest-room tracker, and sets rooms_in_use to 16.
// A finished grant sits in the output register; a stalled grant_ready holds the
// next job's write-back until the register frees, and a new job beat is taken
// while the previous grant is still waiting.

module earliest_free_room_allocator_core #(
    parameter int ROOMS = efra_pkg::ROOMS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  efra_pkg::job_beat_t         job,
    output logic                        grant_valid,
    input  logic                        grant_ready,
    output efra_pkg::grant_beat_t       grant,
    input  logic                        wr_en,
    input  logic [efra_pkg::CFG_W-1:0]  wr_data
);

    localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int TW    = efra_pkg::TIME_W;
    localparam int SW    = efra_pkg::START_W;
    localparam int CW    = efra_pkg::COUNT_W;
    localparam int RW    = efra_pkg::ROOM_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    efra_pkg::state_t            state_reg, state_next;
    logic [efra_pkg::CFG_W-1:0]  rooms_reg;
    logic [SW-1:0]               start_reg;
    logic [SW-1:0]               dur_reg;
    logic                        launch_reg;

    // captured scan result
    logic                        res_found_reg;
    logic [IDX_W-1:0]            res_pick_reg;
    logic [TW-1:0]               res_time_reg;
    logic [CW-1:0]               res_count_reg;

    // running busiest room
    logic [IDX_W-1:0]            leader_room_reg;
    logic [CW-1:0]               leader_count_reg;

    logic                        grant_valid_reg;
    efra_pkg::grant_beat_t       grant_reg;

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    logic                        job_take;
    logic                        scan_end;
    logic                        slot_free;
    logic                        commit_fire;

    efra_pkg::scan_rec_t         rec_chain  [ROOMS+1];
    logic [IDX_W-1:0]            pick_chain [ROOMS+1];
    efra_pkg::commit_t           commit;

    // write-back arithmetic
    logic [TW-1:0]               begin_time;
    logic [TW:0]                 sum;
    logic [TW-1:0]               finish;
    logic [CW-1:0]               new_count;
    logic                        leader_take;

    assign job_take  = job_valid && job_ready;
    assign scan_end  = rec_chain[ROOMS].valid;
    assign slot_free = !grant_valid_reg || grant_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            efra_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = efra_pkg::ST_SCAN;
                end
            end
            efra_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = efra_pkg::ST_DONE;
                end
            end
            efra_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = efra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = efra_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        job_ready   = 1'b0;
        commit_fire = 1'b0;
        case (state_reg)
            efra_pkg::ST_IDLE:
            begin
                job_ready = 1'b1;
            end
            efra_pkg::ST_SCAN:
            begin
                job_ready = 1'b0;
            end
            efra_pkg::ST_DONE:
            begin
                commit_fire = slot_free;
            end
            default:
            begin
                job_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= efra_pkg::ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= job_take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rooms_reg <= efra_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            rooms_reg <= wr_data;
        end
    end

    // latch the job; a non-positive span books zero time
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            start_reg <= job.req_start;
            dur_reg   <= (job.end_time > job.req_start) ?
                         (job.end_time - job.req_start) : '0;
        end
    end

    // ---------------------------------------------------------------
    // Cell chain: record enters at cell 0 with "nothing found yet"
    // ---------------------------------------------------------------
    assign rec_chain[0].valid      = launch_reg;
    assign rec_chain[0].found      = 1'b0;
    assign rec_chain[0].best_time  = {TW{1'b1}};
    assign rec_chain[0].best_count = '0;
    assign pick_chain[0]           = '0;

    assign commit.en     = commit_fire;
    assign commit.finish = finish;

    for (genvar g = 0; g < ROOMS; g++)
    begin : g_cell
        efra_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .rooms_in_use (rooms_reg),
            .req_start    (start_reg),
            .rec_in       (rec_chain[g]),
            .pick_in      (pick_chain[g]),
            .rec_out      (rec_chain[g+1]),
            .pick_out     (pick_chain[g+1]),
            .commit       (commit),
            .commit_pick  (res_pick_reg)
        );
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == efra_pkg::ST_SCAN) && scan_end)
        begin
            res_found_reg <= rec_chain[ROOMS].found;
            res_pick_reg  <= pick_chain[ROOMS];
            res_time_reg  <= rec_chain[ROOMS].best_time;
            res_count_reg <= rec_chain[ROOMS].best_count;
        end
    end

    // ---------------------------------------------------------------
    // Write-back: start is the request if a room was free, else the
    // earliest free time; end saturates at the top of the time range.
    // ---------------------------------------------------------------
    assign begin_time = res_found_reg ? {{(TW-SW){1'b0}}, start_reg} : res_time_reg;
    assign sum        = {1'b0, begin_time} + {{(TW+1-SW){1'b0}}, dur_reg};
    assign finish     = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
    assign new_count  = (res_count_reg == {CW{1'b1}}) ? res_count_reg
                                                      : res_count_reg + CW'(1);
    assign leader_take = (new_count > leader_count_reg) ||
                         ((new_count == leader_count_reg) &&
                          (res_pick_reg < leader_room_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_room_reg  <= '0;
            leader_count_reg <= '0;
        end
        else if (commit_fire && leader_take)
        begin
            leader_room_reg  <= res_pick_reg;
            leader_count_reg <= new_count;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_valid_reg <= 1'b0;
        end
        else if (commit_fire)
        begin
            grant_valid_reg <= 1'b1;
        end
        else if (grant_ready)
        begin
            grant_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_fire)
        begin
            grant_reg.room         <= RW'(res_pick_reg);
            grant_reg.actual_start <= begin_time;
            grant_reg.actual_end   <= finish;
            grant_reg.busiest_room <= leader_take ? RW'(res_pick_reg)
                                                  : RW'(leader_room_reg);
        end
    end

    assign grant_valid = grant_valid_reg;
    assign grant       = grant_reg;

endmodule
